### rtl/scc_pkg.sv
// Shared widths, register indexes, the pipeline context type and helpers
// for the segment and circle crossing unit. No dependencies.
package scc_pkg;

   // coordinate, difference and dot product widths
   localparam int XW = 32;
   localparam int DW = XW + 1;
   localparam int SW = 68;
   localparam int AW = 66;

   // pipelined multiplier: magnitude width, digit width, stage count
   localparam int MUL_W  = 72;
   localparam int MUL_D  = 18;
   localparam int MUL_N  = MUL_W / MUL_D;
   localparam int MUL_L  = MUL_N + 1;
   localparam int PROD_W = 2 * MUL_W + 1;

   // square root and divider sizes
   localparam int RAD_W  = 128;
   localparam int ROOT_W = RAD_W / 2;
   localparam int SQR_W  = ROOT_W + 3;
   localparam int DIV_N  = 34;
   localparam int REM_W  = 101;

   localparam int NUM_MUL = 13;

   // register indexes of the write port
   localparam int CSR_IW = 2;
   localparam logic [CSR_IW-1:0] CSR_CENTER_X  = 2'd0;
   localparam logic [CSR_IW-1:0] CSR_CENTER_Y  = 2'd1;
   localparam logic [CSR_IW-1:0] CSR_RADIUS    = 2'd2;
   localparam logic [CSR_IW-1:0] CSR_EXIT_MODE = 2'd3;

   // per-request context that travels beside the arithmetic
   typedef struct packed {
      logic                 kill;
      logic                 big;
      logic                 sx;
      logic                 sy;
      logic signed [XW-1:0] px;
      logic signed [XW-1:0] py;
      logic signed [XW-1:0] cx;
      logic signed [XW-1:0] cy;
      logic signed [DW-1:0] dx;
      logic signed [DW-1:0] dy;
      logic [AW-1:0]        a;
      logic signed [SW-1:0] h;
   } ctx_type;

   // magnitude of a sign-extended operand
   function automatic logic [MUL_W-1:0] mag_of(input logic signed [MUL_W-1:0] v);
      return v[MUL_W-1] ? MUL_W'(-v) : MUL_W'(v);
   endfunction

endpackage

### rtl/scc_mul.sv
// Pipelined sign-magnitude multiplier, one digit of the second operand
// per stage, then a signing stage. Depends on scc_pkg.
module scc_mul import scc_pkg::*; (
   input  logic                     clock,
   input  logic                     en,
   input  logic [MUL_W-1:0]         a_mag,
   input  logic [MUL_W-1:0]         b_mag,
   input  logic                     neg,
   output logic signed [PROD_W-1:0] prod
);
   localparam int AccW = 2 * MUL_W;

   logic [MUL_W-1:0]        a_ff   [MUL_N];
   logic [MUL_W-1:0]        b_ff   [MUL_N];
   logic [AccW-1:0]         acc_ff [MUL_N];
   logic                    neg_ff [MUL_N];
   logic signed [PROD_W-1:0] prod_ff;

   // accumulate one partial product per stage
   for (genvar k = 0; k < MUL_N; k++) begin : g_stage
      logic [MUL_W-1:0]       a_in;
      logic [MUL_W-1:0]       b_in;
      logic [AccW-1:0]        acc_in;
      logic                   neg_in;
      logic [MUL_W+MUL_D-1:0] pp;
      if (k == 0) begin : g_first
         assign a_in   = a_mag;
         assign b_in   = b_mag;
         assign acc_in = '0;
         assign neg_in = neg;
      end else begin : g_next
         assign a_in   = a_ff[k-1];
         assign b_in   = b_ff[k-1];
         assign acc_in = acc_ff[k-1];
         assign neg_in = neg_ff[k-1];
      end
      assign pp = a_in * b_in[k*MUL_D +: MUL_D];
      always_ff @(posedge clock) begin
         if (en) begin
            a_ff[k]   <= a_in;
            b_ff[k]   <= b_in;
            neg_ff[k] <= neg_in;
            acc_ff[k] <= acc_in + (AccW'(pp) << (k * MUL_D));
         end
      end
   end

   // apply the sign
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= neg_ff[MUL_N-1] ? -$signed({1'b0, acc_ff[MUL_N-1]})
                                    :  $signed({1'b0, acc_ff[MUL_N-1]});
      end
   end

   assign prod = prod_ff;

endmodule

### rtl/scc_sqrt.sv
// Pipelined floor square root, one root bit per stage, with the request
// context carried alongside. Depends on scc_pkg.
module scc_sqrt import scc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  rad,
   input  ctx_type           in_ctx,
   output logic              out_valid,
   output logic [ROOT_W-1:0] root,
   output ctx_type           out_ctx
);
   logic                v_ff    [ROOT_W];
   logic [SQR_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   ctx_type             ctx_ff  [ROOT_W];

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic              v_p;
      logic [SQR_W-1:0]  rem_p;
      logic [ROOT_W-1:0] root_p;
      logic [RAD_W-1:0]  rad_p;
      ctx_type           ctx_p;
      logic [SQR_W-1:0]  remw;
      logic [SQR_W-1:0]  trial;
      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rem_p  = '0;
         assign root_p = '0;
         assign rad_p  = rad;
         assign ctx_p  = in_ctx;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign ctx_p  = ctx_ff[k-1];
      end

      // bring down two radicand bits, try the next root bit
      assign remw  = {rem_p[SQR_W-3:0], rad_p[RAD_W-1 -: 2]};
      assign trial = SQR_W'({root_p, 2'b01});

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (en) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            if (remw >= trial) begin
               rem_ff[k]  <= remw - trial;
               root_ff[k] <= {root_p[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff[k]  <= remw;
               root_ff[k] <= {root_p[ROOT_W-2:0], 1'b0};
            end
            rad_ff[k] <= rad_p << 2;
            ctx_ff[k] <= ctx_p;
         end
      end
   end

   assign out_valid = v_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign out_ctx   = ctx_ff[ROOT_W-1];

endmodule

### rtl/segment_circle_cross_point_unit.sv
// Segment and circle crossing unit: top level with the full pipeline.
// Depends on scc_pkg, scc_mul and scc_sqrt.
//
// Use: each request on req_ carries a previous point, a next point and a
// candidate point (Q24.8). The line through the two points is cut with the
// circle set through the csr_ write port (center, radius, exit mode). Each
// request yields one response on rsp_: rsp_tuser is high when the crossing
// replaced the candidate, rsp_tdata holds the point.
// Throughput: one request per cycle while the output does not stall; the
// pipeline is fixed in depth, set by the 64-stage root and the 34-stage
// quotient on top of three 5-stage multiplier banks.
// Reset clears the valid bits and the csr_ registers to zero.
// When the receiver stalls, the response holds in the output register and
// one more lands in a skid register; then req_tready drops and the whole
// pipeline holds until the skid register drains.
module segment_circle_cross_point_unit import scc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // prev_x, prev_y, next_x, next_y, cand_x, cand_y
   input  logic [6*XW-1:0]    req_tdata,
   input  logic               req_tvalid,
   output logic               req_tready,
   // point_x, point_y
   output logic [2*XW-1:0]    rsp_tdata,
   // crossed
   output logic [0:0]         rsp_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   input  logic               csr_we,
   input  logic [CSR_IW-1:0]  csr_index,
   input  logic [XW-1:0]      csr_wdata
);
   logic signed [XW-1:0] center_x_ff, center_y_ff;
   logic [XW-2:0]        radius_ff;
   logic                 exit_mode_ff;
   logic                 en;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff  <= '0;
         center_y_ff  <= '0;
         radius_ff    <= '0;
         exit_mode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CENTER_X:  center_x_ff  <= csr_wdata;
            CSR_CENTER_Y:  center_y_ff  <= csr_wdata;
            CSR_RADIUS:    radius_ff    <= csr_wdata[XW-2:0];
            CSR_EXIT_MODE: exit_mode_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ---------------- stage 0: differences ----------------
   logic signed [XW-1:0] px_in, py_in, nx_in, ny_in, cx_in, cy_in;
   logic                 v0_ff;
   logic signed [DW-1:0] opa_ff [NUM_MUL];
   logic signed [DW-1:0] opb_ff [NUM_MUL];
   logic signed [DW-1:0] opa_in [NUM_MUL];
   logic signed [DW-1:0] opb_in [NUM_MUL];
   ctx_type              ctx0_ff, ctx0_in;
   logic signed [DW-1:0] dx_in, dy_in, qx_in, qy_in, mx_in, my_in;
   logic signed [DW-1:0] ex_in, ey_in, fx_in, fy_in;

   assign px_in = req_tdata[0*XW +: XW];
   assign py_in = req_tdata[1*XW +: XW];
   assign nx_in = req_tdata[2*XW +: XW];
   assign ny_in = req_tdata[3*XW +: XW];
   assign cx_in = req_tdata[4*XW +: XW];
   assign cy_in = req_tdata[5*XW +: XW];

   always_comb begin
      dx_in = DW'(nx_in) - DW'(px_in);
      dy_in = DW'(ny_in) - DW'(py_in);
      qx_in = DW'(px_in) - DW'(center_x_ff);
      qy_in = DW'(py_in) - DW'(center_y_ff);
      mx_in = DW'(nx_in) - DW'(center_x_ff);
      my_in = DW'(ny_in) - DW'(center_y_ff);
      ex_in = DW'(cx_in) - DW'(px_in);
      ey_in = DW'(cy_in) - DW'(py_in);
      fx_in = DW'(cx_in) - DW'(nx_in);
      fy_in = DW'(cy_in) - DW'(ny_in);
      // product list: |Q|^2, |N-c|^2, |D|^2, D.Q, D.(C-P), D.(C-N), r^2
      opa_in[0]  = qx_in;  opb_in[0]  = qx_in;
      opa_in[1]  = qy_in;  opb_in[1]  = qy_in;
      opa_in[2]  = mx_in;  opb_in[2]  = mx_in;
      opa_in[3]  = my_in;  opb_in[3]  = my_in;
      opa_in[4]  = dx_in;  opb_in[4]  = dx_in;
      opa_in[5]  = dy_in;  opb_in[5]  = dy_in;
      opa_in[6]  = dx_in;  opb_in[6]  = qx_in;
      opa_in[7]  = dy_in;  opb_in[7]  = qy_in;
      opa_in[8]  = dx_in;  opb_in[8]  = ex_in;
      opa_in[9]  = dy_in;  opb_in[9]  = ey_in;
      opa_in[10] = dx_in;  opb_in[10] = fx_in;
      opa_in[11] = dy_in;  opb_in[11] = fy_in;
      opa_in[12] = $signed({2'b00, radius_ff});
      opb_in[12] = $signed({2'b00, radius_ff});
      ctx0_in      = '0;
      ctx0_in.px   = px_in;
      ctx0_in.py   = py_in;
      ctx0_in.cx   = cx_in;
      ctx0_in.cy   = cy_in;
      ctx0_in.dx   = dx_in;
      ctx0_in.dy   = dy_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         opa_ff  <= opa_in;
         opb_ff  <= opb_in;
         ctx0_ff <= ctx0_in;
      end
   end

   // ---------------- bank B: first products ----------------
   logic signed [PROD_W-1:0] pb [NUM_MUL];
   logic    vb_ff   [MUL_L];
   ctx_type ctxb_ff [MUL_L];

   for (genvar i = 0; i < NUM_MUL; i++) begin : g_mul_b
      scc_mul u_mul (
         .clock (clock),
         .en    (en),
         .a_mag (mag_of(MUL_W'(opa_ff[i]))),
         .b_mag (mag_of(MUL_W'(opb_ff[i]))),
         .neg   (opa_ff[i][DW-1] ^ opb_ff[i][DW-1]),
         .prod  (pb[i])
      );
   end

   // delay the context beside the multipliers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_L; k++) vb_ff[k] <= 1'b0;
      end else if (en) begin
         vb_ff[0] <= v0_ff;
         for (int k = 1; k < MUL_L; k++) vb_ff[k] <= vb_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctxb_ff[0] <= ctx0_ff;
         for (int k = 1; k < MUL_L; k++) ctxb_ff[k] <= ctxb_ff[k-1];
      end
   end

   // ---------------- stage C1: dot product sums ----------------
   logic                 v1_ff;
   ctx_type              ctx1_ff;
   logic signed [SW-1:0] pd1_ff, nd1_ff, a1_ff, h1_ff, t1_ff, t2_ff, r2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= vb_ff[MUL_L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx1_ff <= ctxb_ff[MUL_L-1];
         pd1_ff  <= SW'(pb[0]) + SW'(pb[1]);
         nd1_ff  <= SW'(pb[2]) + SW'(pb[3]);
         a1_ff   <= SW'(pb[4]) + SW'(pb[5]);
         h1_ff   <= SW'(pb[6]) + SW'(pb[7]);
         t1_ff   <= SW'(pb[8]) + SW'(pb[9]);
         t2_ff   <= SW'(pb[10]) + SW'(pb[11]);
         r2_ff   <= SW'(pb[12]);
      end
   end

   // ---------------- stage C2: inside tests, early drop ----------------
   logic                 v2_ff;
   ctx_type              ctx2_ff, ctx2_in;
   logic signed [SW-1:0] c2_ff;
   logic                 prev_out, next_out;

   always_comb begin
      prev_out      = pd1_ff > r2_ff;
      next_out      = nd1_ff > r2_ff;
      ctx2_in       = ctx1_ff;
      ctx2_in.a     = AW'(a1_ff);
      ctx2_in.h     = h1_ff;
      // drop when both inside, points coincide or candidate is off segment
      ctx2_in.kill  = (!prev_out && !next_out) || (a1_ff == '0) || t1_ff[SW-1]
                      || (!t2_ff[SW-1] && (t2_ff != '0));
      ctx2_in.big   = (prev_out && exit_mode_ff) || (!prev_out && next_out);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctx2_ff <= ctx2_in;
         c2_ff   <= pd1_ff - r2_ff;
      end
   end

   // ---------------- bank D: h*h and a*c ----------------
   logic signed [PROD_W-1:0] phh, pac;
   logic    vd_ff   [MUL_L];
   ctx_type ctxd_ff [MUL_L];

   scc_mul u_mul_hh (
      .clock (clock),
      .en    (en),
      .a_mag (mag_of(MUL_W'(ctx2_ff.h))),
      .b_mag (mag_of(MUL_W'(ctx2_ff.h))),
      .neg   (1'b0),
      .prod  (phh)
   );

   scc_mul u_mul_ac (
      .clock (clock),
      .en    (en),
      .a_mag (MUL_W'(ctx2_ff.a)),
      .b_mag (mag_of(MUL_W'(c2_ff))),
      .neg   (c2_ff[SW-1]),
      .prod  (pac)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_L; k++) vd_ff[k] <= 1'b0;
      end else if (en) begin
         vd_ff[0] <= v2_ff;
         for (int k = 1; k < MUL_L; k++) vd_ff[k] <= vd_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctxd_ff[0] <= ctx2_ff;
         for (int k = 1; k < MUL_L; k++) ctxd_ff[k] <= ctxd_ff[k-1];
      end
   end

   // ---------------- stage E: discriminant ----------------
   logic                     ve_ff;
   ctx_type                  ctxe_ff, ctxe_in;
   logic [RAD_W-1:0]         rade_ff;
   logic signed [PROD_W-1:0] disc;

   always_comb begin
      disc         = phh - pac;
      ctxe_in      = ctxd_ff[MUL_L-1];
      ctxe_in.kill = ctxd_ff[MUL_L-1].kill || disc[PROD_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ve_ff <= 1'b0;
      end else if (en) begin
         ve_ff <= vd_ff[MUL_L-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctxe_ff <= ctxe_in;
         rade_ff <= disc[RAD_W-1:0];
      end
   end

   // ---------------- square root ----------------
   logic              vf;
   logic [ROOT_W-1:0] sroot;
   ctx_type           ctxf;

   scc_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (ve_ff),
      .rad       (rade_ff),
      .in_ctx    (ctxe_ff),
      .out_valid (vf),
      .root      (sroot),
      .out_ctx   (ctxf)
   );

   // ---------------- stage G: root numerator ----------------
   logic                 vg_ff;
   ctx_type              ctxg_ff, ctxg_in;
   logic signed [SW-1:0] ng_ff, n_in, s_ext;

   always_comb begin
      s_ext      = $signed({{(SW-ROOT_W){1'b0}}, sroot});
      n_in       = ctxf.big ? (s_ext - ctxf.h) : -(ctxf.h + s_ext);
      ctxg_in    = ctxf;
      ctxg_in.sx = ctxf.dx[DW-1] ^ n_in[SW-1];
      ctxg_in.sy = ctxf.dy[DW-1] ^ n_in[SW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vg_ff <= 1'b0;
      end else if (en) begin
         vg_ff <= vf;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctxg_ff <= ctxg_in;
         ng_ff   <= n_in;
      end
   end

   // ---------------- bank H: |d*n| per axis ----------------
   logic signed [PROD_W-1:0] phx, phy;
   logic    vh_ff   [MUL_L];
   ctx_type ctxh_ff [MUL_L];

   scc_mul u_mul_x (
      .clock (clock),
      .en    (en),
      .a_mag (mag_of(MUL_W'(ctxg_ff.dx))),
      .b_mag (mag_of(MUL_W'(ng_ff))),
      .neg   (1'b0),
      .prod  (phx)
   );

   scc_mul u_mul_y (
      .clock (clock),
      .en    (en),
      .a_mag (mag_of(MUL_W'(ctxg_ff.dy))),
      .b_mag (mag_of(MUL_W'(ng_ff))),
      .neg   (1'b0),
      .prod  (phy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < MUL_L; k++) vh_ff[k] <= 1'b0;
      end else if (en) begin
         vh_ff[0] <= vg_ff;
         for (int k = 1; k < MUL_L; k++) vh_ff[k] <= vh_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctxh_ff[0] <= ctxg_ff;
         for (int k = 1; k < MUL_L; k++) ctxh_ff[k] <= ctxh_ff[k-1];
      end
   end

   // ---------------- stage I0: rounding numerators ----------------
   logic             vi_ff;
   ctx_type          ctxi_ff;
   logic [REM_W-1:0] numx_ff, numy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vi_ff <= 1'b0;
      end else if (en) begin
         vi_ff <= vh_ff[MUL_L-1];
      end
   end

   // round to nearest: (2|num| + a) / (2a)
   always_ff @(posedge clock) begin
      if (en) begin
         ctxi_ff <= ctxh_ff[MUL_L-1];
         numx_ff <= {phx[REM_W-2:0], 1'b0} + REM_W'(ctxh_ff[MUL_L-1].a);
         numy_ff <= {phy[REM_W-2:0], 1'b0} + REM_W'(ctxh_ff[MUL_L-1].a);
      end
   end

   // ---------------- divider: one quotient bit per stage ----------------
   // the top quotient bit marks a quotient too large for any coordinate
   logic             dv_ff   [DIV_N];
   ctx_type          dctx_ff [DIV_N];
   logic [REM_W-1:0] remx_ff [DIV_N];
   logic [REM_W-1:0] remy_ff [DIV_N];
   logic [DIV_N-1:0] qx_ff   [DIV_N];
   logic [DIV_N-1:0] qy_ff   [DIV_N];

   for (genvar k = 0; k < DIV_N; k++) begin : g_div
      logic             v_p;
      ctx_type          ctx_p;
      logic [REM_W-1:0] rx_p, ry_p, den_sh;
      logic [DIV_N-1:0] qx_p, qy_p;
      logic             gex, gey;
      if (k == 0) begin : g_first
         assign v_p   = vi_ff;
         assign ctx_p = ctxi_ff;
         assign rx_p  = numx_ff;
         assign ry_p  = numy_ff;
         assign qx_p  = '0;
         assign qy_p  = '0;
      end else begin : g_next
         assign v_p   = dv_ff[k-1];
         assign ctx_p = dctx_ff[k-1];
         assign rx_p  = remx_ff[k-1];
         assign ry_p  = remy_ff[k-1];
         assign qx_p  = qx_ff[k-1];
         assign qy_p  = qy_ff[k-1];
      end
      assign den_sh = REM_W'({ctx_p.a, 1'b0}) << (DIV_N - 1 - k);
      assign gex    = rx_p >= den_sh;
      assign gey    = ry_p >= den_sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k] <= 1'b0;
         end else if (en) begin
            dv_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dctx_ff[k] <= ctx_p;
            remx_ff[k] <= gex ? (rx_p - den_sh) : rx_p;
            remy_ff[k] <= gey ? (ry_p - den_sh) : ry_p;
            qx_ff[k]   <= {qx_p[DIV_N-2:0], gex};
            qy_ff[k]   <= {qy_p[DIV_N-2:0], gey};
         end
      end
   end

   // ---------------- final placement and saturation ----------------
   function automatic logic [XW-1:0] place_fn(input logic signed [XW-1:0] p,
                                              input logic [DIV_N-1:0] q,
                                              input logic neg);
      logic signed [XW+2:0] pe, qe, v;
      pe = (XW+3)'(p);
      qe = $signed({2'b00, q[DIV_N-2:0]});
      v  = neg ? (pe - qe) : (pe + qe);
      if (q[DIV_N-1]) begin
         return neg ? {1'b1, {(XW-1){1'b0}}} : {1'b0, {(XW-1){1'b1}}};
      end else if (v > (XW+3)'(33'sh0_7FFF_FFFF)) begin
         return {1'b0, {(XW-1){1'b1}}};
      end else if (v < -(XW+3)'(33'sh0_8000_0000)) begin
         return {1'b1, {(XW-1){1'b0}}};
      end
      return v[XW-1:0];
   endfunction

   ctx_type       fctx;
   logic          fv;
   logic          fin_cross;
   logic [XW-1:0] fin_x, fin_y;

   always_comb begin
      fctx      = dctx_ff[DIV_N-1];
      fv        = dv_ff[DIV_N-1];
      fin_cross = !fctx.kill;
      fin_x     = fctx.kill ? fctx.cx : place_fn(fctx.px, qx_ff[DIV_N-1], fctx.sx);
      fin_y     = fctx.kill ? fctx.cy : place_fn(fctx.py, qy_ff[DIV_N-1], fctx.sy);
   end

   // ---------------- output register and skid register ----------------
   logic          out_v_ff, skid_v_ff;
   logic          out_c_ff, skid_c_ff;
   logic [XW-1:0] out_x_ff, out_y_ff, skid_x_ff, skid_y_ff;
   logic          take;

   assign take       = out_v_ff && rsp_tready;
   assign en         = !skid_v_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         // drain the skid register first; the pipeline holds meanwhile
         if (take) begin
            out_c_ff  <= skid_c_ff;
            out_x_ff  <= skid_x_ff;
            out_y_ff  <= skid_y_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (fv) begin
         if (!out_v_ff || take) begin
            out_v_ff <= 1'b1;
            out_c_ff <= fin_cross;
            out_x_ff <= fin_x;
            out_y_ff <= fin_y;
         end else begin
            skid_v_ff <= 1'b1;
            skid_c_ff <= fin_cross;
            skid_x_ff <= fin_x;
            skid_y_ff <= fin_y;
         end
      end else if (take) begin
         out_v_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {out_y_ff, out_x_ff};
   assign rsp_tuser  = out_c_ff;

endmodule

### rtl/scc_check.sv
// Port-level checker for the segment and circle crossing unit, bound to
// the top level. Depends on scc_pkg.
module scc_check import scc_pkg::*; (
   input logic            clock,
   input logic            reset,
   input logic            req_tready,
   input logic            rsp_tvalid,
   input logic            rsp_tready,
   input logic [2*XW-1:0] rsp_tdata,
   input logic [0:0]      rsp_tuser
);
   // hold a stalled response
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // no response right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // requests are refused only while a response is waiting
   assert property (@(posedge clock) disable iff (reset) !req_tready |-> rsp_tvalid)
      else $error("request refused with empty output");

   // a drop of req_tready means the output was stalled the cycle before
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(rsp_tvalid && !rsp_tready))
      else $error("ready dropped without an output stall");

endmodule

bind segment_circle_cross_point_unit scc_check u_check (.*);
